[rtl/rmfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_pkg
// Shared codes, constants and types for the relay frame protocol master.
// ----------------------------------------------------------------------------
package rmfp_pkg;

    // request codes on req_type
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;

    // register kinds on reg_kind
    localparam logic [1:0] KIND_RELAY  = 2'd0;
    localparam logic [1:0] KIND_BRIGHT = 2'd3;

    // frame bytes
    localparam logic [7:0] CMD_READ   = 8'h05;
    localparam logic [7:0] CMD_WRITE  = 8'h06;
    localparam logic [7:0] CMD_BRIGHT = 8'h0A;
    localparam logic [7:0] PREAMBLE   = 8'hFF;
    localparam logic [7:0] RELAY_ON   = 8'hFF;

    // frame and reply geometry
    localparam int FRAME_LEN  = 8;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
    localparam int BODY_LEN   = 5;
    localparam int BODY_CNT_W = $clog2(BODY_LEN + 1);
    localparam int BODY_KEEP  = 4;                 // last body byte is only summed, not kept
    localparam int BODY_IDX_W = $clog2(BODY_KEEP);

    // frame byte positions
    localparam logic [FRAME_IDX_W-1:0] POS_PRE0  = 3'd0;
    localparam logic [FRAME_IDX_W-1:0] POS_PRE1  = 3'd1;
    localparam logic [FRAME_IDX_W-1:0] POS_CMD   = 3'd2;
    localparam logic [FRAME_IDX_W-1:0] POS_SLAVE = 3'd3;
    localparam logic [FRAME_IDX_W-1:0] POS_B1    = 3'd4;
    localparam logic [FRAME_IDX_W-1:0] POS_B2    = 3'd5;
    localparam logic [FRAME_IDX_W-1:0] POS_B3    = 3'd6;
    localparam logic [FRAME_IDX_W-1:0] POS_SUM   = 3'd7;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_BAD_CMD  = 3'd2,
        ST_BAD_MOD  = 3'd3,
        ST_INDEX    = 3'd4,
        ST_VALUE    = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PRE1 = 5'b00010,
        PH_PRE2 = 5'b00100,
        PH_BODY = 5'b01000,
        PH_SUM  = 5'b10000
    } phase_t;

    // result descriptor handed from the parser to the output stage
    typedef struct packed {
        logic       frame;       // send an 8-byte request frame
        logic       done;        // send one done result
        logic [7:0] cmd;
        logic [7:0] slave;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] sum;
        status_t    status;
        logic [7:0] read_value;
    } rslt_t;

endpackage
`default_nettype wire

[rtl/rmfp_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_parser
// Request encoding and reply parsing. State advances on each consumed item;
// the result descriptor is combinational from the input register.
// ----------------------------------------------------------------------------
module rmfp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [1:0]      req_type,
    input  wire logic [1:0]      reg_kind,
    input  wire logic [15:0]     reg_address,
    input  wire logic [7:0]      write_value,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [7:0]      slave_id,
    output rmfp_pkg::rslt_t      rslt
);

    rmfp_pkg::phase_t                   phase_reg, phase_next;
    logic [7:0]                         exp_cmd_reg, exp_cmd_next;
    logic [7:0]                         exp_idx_reg, exp_idx_next;
    logic [7:0]                         exp_val_reg, exp_val_next;
    logic                               relay_reg, relay_next;
    logic                               write_reg, write_next;
    logic [rmfp_pkg::BODY_CNT_W-1:0]    count_reg, count_next;
    logic [7:0]                         sum_reg, sum_next;
    logic [7:0]                         body_reg  [rmfp_pkg::BODY_KEEP];
    logic [7:0]                         body_next [rmfp_pkg::BODY_KEEP];

    logic [7:0] wr_val;
    logic [7:0] wr_cmd;
    logic [7:0] wr_idx;

    // write request operands
    always_comb
    begin
        wr_val = (reg_kind == rmfp_pkg::KIND_RELAY && write_value != 8'd0)
                 ? rmfp_pkg::RELAY_ON : write_value;
        if (reg_kind == rmfp_pkg::KIND_BRIGHT)
        begin
            wr_cmd = rmfp_pkg::CMD_BRIGHT;
            wr_idx = reg_address[15:8];
        end
        else
        begin
            wr_cmd = rmfp_pkg::CMD_WRITE;
            wr_idx = reg_address[7:0];
        end
    end

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        exp_cmd_next = exp_cmd_reg;
        exp_idx_next = exp_idx_reg;
        exp_val_next = exp_val_reg;
        relay_next   = relay_reg;
        write_next   = write_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        body_next    = body_reg;
        rslt         = '0;
        rslt.slave   = slave_id;

        case (req_type)
            rmfp_pkg::REQ_READ:
            begin
                exp_cmd_next = rmfp_pkg::CMD_READ;
                exp_idx_next = reg_address[7:0];
                exp_val_next = 8'd0;
                relay_next   = (reg_kind == rmfp_pkg::KIND_RELAY);
                write_next   = 1'b0;
                phase_next   = rmfp_pkg::PH_PRE1;
                count_next   = '0;
                sum_next     = 8'd0;
                rslt.frame   = 1'b1;
                rslt.cmd     = rmfp_pkg::CMD_READ;
                rslt.b1      = 8'd0;
                rslt.b2      = reg_address[7:0];
                rslt.sum     = rmfp_pkg::CMD_READ + slave_id + reg_address[7:0];
            end
            rmfp_pkg::REQ_WRITE:
            begin
                exp_cmd_next = wr_cmd;
                exp_idx_next = wr_idx;
                exp_val_next = wr_val;
                relay_next   = (reg_kind == rmfp_pkg::KIND_RELAY);
                write_next   = 1'b1;
                phase_next   = rmfp_pkg::PH_PRE1;
                count_next   = '0;
                sum_next     = 8'd0;
                rslt.frame   = 1'b1;
                rslt.cmd     = wr_cmd;
                rslt.b1      = wr_val;
                rslt.b2      = wr_idx;
                rslt.sum     = wr_cmd + slave_id + wr_val + wr_idx;
            end
            rmfp_pkg::REQ_RX:
            begin
                case (phase_reg)
                    rmfp_pkg::PH_PRE1:
                    begin
                        if (rx_byte == rmfp_pkg::PREAMBLE)
                            phase_next = rmfp_pkg::PH_PRE2;
                    end
                    rmfp_pkg::PH_PRE2:
                    begin
                        phase_next = (rx_byte == rmfp_pkg::PREAMBLE)
                                     ? rmfp_pkg::PH_BODY : rmfp_pkg::PH_PRE1;
                        count_next = '0;
                        sum_next   = 8'd0;
                    end
                    rmfp_pkg::PH_BODY:
                    begin
                        if (count_reg < rmfp_pkg::BODY_CNT_W'(rmfp_pkg::BODY_KEEP))
                            body_next[count_reg[rmfp_pkg::BODY_IDX_W-1:0]] = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        count_next = count_reg + 1'b1;
                        if (count_reg == rmfp_pkg::BODY_CNT_W'(rmfp_pkg::BODY_LEN - 1))
                            phase_next = rmfp_pkg::PH_SUM;
                    end
                    rmfp_pkg::PH_SUM:
                    begin
                        rslt.done = 1'b1;
                        // first failing check wins
                        if (rx_byte != sum_reg)
                            rslt.status = rmfp_pkg::ST_CHECKSUM;
                        else if (body_reg[0] != exp_cmd_reg)
                            rslt.status = rmfp_pkg::ST_BAD_CMD;
                        else if (body_reg[1] != 8'd0)
                            rslt.status = rmfp_pkg::ST_BAD_MOD;
                        else if (body_reg[3] != exp_idx_reg)
                            rslt.status = rmfp_pkg::ST_INDEX;
                        else if (write_reg && body_reg[2] != exp_val_reg)
                            rslt.status = rmfp_pkg::ST_VALUE;
                        else
                            rslt.status = rmfp_pkg::ST_OK;
                        if (rslt.status == rmfp_pkg::ST_OK && !write_reg)
                            rslt.read_value = relay_reg ? {7'd0, body_reg[2] != 8'd0}
                                                        : body_reg[2];
                        phase_next = rmfp_pkg::PH_IDLE;
                        count_next = '0;
                        sum_next   = 8'd0;
                    end
                    default:
                    begin
                        // idle: byte dropped
                    end
                endcase
            end
            default:
            begin
                // unused request code: no effect
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rmfp_pkg::PH_IDLE;
            exp_cmd_reg <= 8'd0;
            exp_idx_reg <= 8'd0;
            exp_val_reg <= 8'd0;
            relay_reg   <= 1'b0;
            write_reg   <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            exp_cmd_reg <= exp_cmd_next;
            exp_idx_reg <= exp_idx_next;
            exp_val_reg <= exp_val_next;
            relay_reg   <= relay_next;
            write_reg   <= write_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
        end
    end

    // reply body bytes, written before read
    always_ff @(posedge clk)
    begin
        if (fire)
            body_reg <= body_next;
    end

endmodule
`default_nettype wire

[rtl/rmfp_tx.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_tx
// Result register. Holds one descriptor and presents it as eight frame
// words or one done word.
// ----------------------------------------------------------------------------
module rmfp_tx (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire rmfp_pkg::rslt_t rslt,
    output logic                 free,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 result_kind,
    output logic [7:0]           tx_byte,
    output logic                 last,
    output logic [2:0]           status,
    output logic [7:0]           read_value
);

    logic                               valid_reg;
    logic                               done_reg;
    logic [rmfp_pkg::FRAME_IDX_W-1:0]   idx_reg;
    logic [7:0]                         cmd_reg;
    logic [7:0]                         slave_reg;
    logic [7:0]                         b1_reg;
    logic [7:0]                         b2_reg;
    logic [7:0]                         sum_reg;
    rmfp_pkg::status_t                  status_reg;
    logic [7:0]                         rv_reg;
    logic                               beat_last;

    // last word of the held result
    assign beat_last = done_reg || (idx_reg == rmfp_pkg::POS_SUM);
    assign free      = !valid_reg || (out_ready && beat_last);

    // sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            done_reg  <= rslt.done;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (beat_last)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg    <= rslt.cmd;
            slave_reg  <= rslt.slave;
            b1_reg     <= rslt.b1;
            b2_reg     <= rslt.b2;
            sum_reg    <= rslt.sum;
            status_reg <= rslt.status;
            rv_reg     <= rslt.read_value;
        end
    end

    // frame byte select
    always_comb
    begin
        case (idx_reg)
            rmfp_pkg::POS_PRE0:  tx_byte = rmfp_pkg::PREAMBLE;
            rmfp_pkg::POS_PRE1:  tx_byte = rmfp_pkg::PREAMBLE;
            rmfp_pkg::POS_CMD:   tx_byte = cmd_reg;
            rmfp_pkg::POS_SLAVE: tx_byte = slave_reg;
            rmfp_pkg::POS_B1:    tx_byte = b1_reg;
            rmfp_pkg::POS_B2:    tx_byte = b2_reg;
            rmfp_pkg::POS_B3:    tx_byte = 8'd0;
            rmfp_pkg::POS_SUM:   tx_byte = sum_reg;
            default:             tx_byte = 8'd0;
        endcase
        if (done_reg)
            tx_byte = 8'd0;
    end

    assign out_valid   = valid_reg;
    assign result_kind = done_reg;
    assign last        = !done_reg && (idx_reg == rmfp_pkg::POS_SUM);
    assign status      = done_reg ? status_reg : rmfp_pkg::ST_OK;
    assign read_value  = done_reg ? rv_reg : 8'd0;

    // a frame in progress never shows as a done word
    a_idx_frame: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != '0 |-> valid_reg && !done_reg)
        else $error("frame index advanced outside a frame");

    // a new descriptor only lands once the held one is fully taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || (out_ready && beat_last))
        else $error("result overwritten before delivery");

    // a frame that is stalled mid-way keeps its position
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready && !load |=> $stable(idx_reg) && valid_reg)
        else $error("frame position moved while stalled");

    // failed transactions report no read value
    a_rv_fail: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg && status_reg != rmfp_pkg::ST_OK |-> read_value == 8'd0)
        else $error("read value on failed transaction");

endmodule
`default_nettype wire

[rtl/relay_module_frame_protocol_master_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// relay_module_frame_protocol_master_top
// Master side of a byte-framed register protocol: request frame encoder and
// reply parser.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle while in_ready is high: a read or
//   write request, or one byte received from the link (req_type).
//   A request yields eight output words, the frame FF FF cmd module b1 b2
//   b3 sum, with last set on the eighth. A reply byte yields nothing until
//   the checksum byte, which yields one done word with status and read_value.
//   Output channel (out_valid/out_ready) carries one word per handshake.
//   An accepted word passes through the input register, then the result
//   register, before its first output word appears. Input words are taken
//   at one per cycle while the held word can move on; a request occupies
//   the result register until all eight frame words are taken, so a
//   following word that has a result waits in the input register until the
//   frame's last word is taken. Reset clears the parser to idle, slave_id
//   to 0 and both channels empty. When the receiver stalls, the held word
//   stays unchanged and the input register fills, after which in_ready drops.
//   slave_id is written through cfg_wr_en/cfg_wr_data; the user must write
//   it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module relay_module_frame_protocol_master_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [1:0]  reg_kind,
    input  wire logic [15:0] reg_address,
    input  wire logic [7:0]  write_value,
    input  wire logic [7:0]  rx_byte,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       tx_byte,
    output logic             last,
    output logic [2:0]       status,
    output logic [7:0]       read_value
);

    logic            s1_valid_reg;
    logic [1:0]      s1_req_reg;
    logic [1:0]      s1_kind_reg;
    logic [15:0]     s1_addr_reg;
    logic [7:0]      s1_wval_reg;
    logic [7:0]      s1_rx_reg;
    logic [7:0]      slave_id_reg;
    logic            s1_fire;
    logic            tx_free;
    logic            has_result;
    rmfp_pkg::rslt_t rslt;

    // slave address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_id_reg <= 8'd0;
        else if (cfg_wr_en)
            slave_id_reg <= cfg_wr_data;
    end

    // input register
    assign has_result = rslt.frame || rslt.done;
    assign s1_fire    = s1_valid_reg && (!has_result || tx_free);
    assign in_ready   = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_req_reg  <= req_type;
            s1_kind_reg <= reg_kind;
            s1_addr_reg <= reg_address;
            s1_wval_reg <= write_value;
            s1_rx_reg   <= rx_byte;
        end
    end

    rmfp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .req_type    (s1_req_reg),
        .reg_kind    (s1_kind_reg),
        .reg_address (s1_addr_reg),
        .write_value (s1_wval_reg),
        .rx_byte     (s1_rx_reg),
        .slave_id    (slave_id_reg),
        .rslt        (rslt)
    );

    rmfp_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire && has_result),
        .rslt        (rslt),
        .free        (tx_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_byte     (tx_byte),
        .last        (last),
        .status      (status),
        .read_value  (read_value)
    );

    // a held word with a pending result blocks the input
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && has_result && !tx_free |-> !in_ready)
        else $error("input accepted over a blocked word");

    // a word without a result never waits
    a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !has_result |-> s1_fire)
        else $error("resultless word stalled");

    // a request never yields a done word
    a_req_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_req_reg == rmfp_pkg::REQ_READ ||
                         s1_req_reg == rmfp_pkg::REQ_WRITE) |-> rslt.frame && !rslt.done)
        else $error("request did not produce a frame");

endmodule
`default_nettype wire

[bench/tb_relay_module_frame_protocol_master_top.sv]
// ----------------------------------------------------------------------------
// tb_relay_module_frame_protocol_master_top
// Self-checking bench for the frame protocol master. A short table of directed
// words, then random request/reply transactions over several slave ids, with
// both channels stalling at random. Every output word is checked against a
// local model of the encoder and reply parser.
// ----------------------------------------------------------------------------
module tb_relay_module_frame_protocol_master_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 100;
    localparam int         HOLD_CYCLES  = 250;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  reg_kind;
        logic [15:0] reg_address;
        logic [7:0]  write_value;
        logic [7:0]  rx_byte;
    } in_word_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        tx;
        logic              last;
        rmfp_pkg::status_t status;
        logic [7:0]        read_value;
    } reply_word_t;

    typedef struct packed {
        in_word_t          w;
        logic              typed;
        rmfp_pkg::status_t st;
        logic [7:0]        rv;
    } dir_row_t;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [1:0]  reg_kind = '0;
    logic [15:0] reg_address = '0;
    logic [7:0]  write_value = '0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  read_value;

    // model state
    logic [7:0]        model_slave = '0;
    rmfp_pkg::phase_t  parse_phase = rmfp_pkg::PH_IDLE;
    logic [7:0]        tgt_cmd = '0;
    logic [7:0]        tgt_index = '0;
    logic [7:0]        tgt_value = '0;
    logic              tgt_relay = 1'b0;
    logic              tgt_write = 1'b0;
    logic [2:0]        rx_count = '0;
    logic [7:0]        rx_sum = '0;
    logic [7:0]        rx_body [rmfp_pkg::BODY_LEN];

    // bookkeeping
    reply_word_t reply_q [$];
    dir_row_t    dir_tab [$];
    int          errors = 0;
    int          items_sent = 0;
    int          words_seen = 0;
    int          frames_sent = 0;
    int          status_seen [6];
    bit          calm = 1'b0;
    bit          hold_done = 1'b0;

    relay_module_frame_protocol_master_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .reg_kind    (reg_kind),
        .reg_address (reg_address),
        .write_value (write_value),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_byte     (tx_byte),
        .last        (last),
        .status      (status),
        .read_value  (read_value)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL relay_module_frame_protocol_master_top");
        $finish;
    end

    // link byte word; request fields carry junk
    function automatic in_word_t rx_w(input logic [7:0] b);
        in_word_t w;
        w.req_type    = rmfp_pkg::REQ_RX;
        w.reg_kind    = 2'($urandom_range(0, 3));
        w.reg_address = 16'($urandom_range(0, 65535));
        w.write_value = 8'($urandom_range(0, 255));
        w.rx_byte     = b;
        return w;
    endfunction

    // request word; rx_byte carries junk
    function automatic in_word_t rq_w(input logic [1:0] t, input logic [1:0] k,
                                      input logic [15:0] a, input logic [7:0] v);
        in_word_t w;
        w.req_type    = t;
        w.reg_kind    = k;
        w.reg_address = a;
        w.write_value = v;
        w.rx_byte     = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // model: apply one accepted word, queue the words it produces
    task automatic predict_word(input in_word_t w, output bit ignored);
        logic [7:0]        cmd, idx, val;
        logic [7:0]        fr [rmfp_pkg::FRAME_LEN];
        rmfp_pkg::status_t st;
        reply_word_t       r;
        ignored = 1'b0;
        if (w.req_type == rmfp_pkg::REQ_READ || w.req_type == rmfp_pkg::REQ_WRITE)
        begin
            // brightness writes use the address high byte and their own command
            if (w.req_type == rmfp_pkg::REQ_WRITE && w.reg_kind == rmfp_pkg::KIND_BRIGHT)
            begin
                cmd = rmfp_pkg::CMD_BRIGHT;
                idx = w.reg_address[15:8];
            end
            else
            begin
                cmd = (w.req_type == rmfp_pkg::REQ_READ) ? rmfp_pkg::CMD_READ
                                                        : rmfp_pkg::CMD_WRITE;
                idx = w.reg_address[7:0];
            end
            if (w.req_type == rmfp_pkg::REQ_READ)
                val = 8'h00;
            else if (w.reg_kind == rmfp_pkg::KIND_RELAY && w.write_value != 8'h00)
                val = rmfp_pkg::RELAY_ON;
            else
                val = w.write_value;
            tgt_cmd     = cmd;
            tgt_index   = idx;
            tgt_value   = val;
            tgt_relay   = (w.reg_kind == rmfp_pkg::KIND_RELAY);
            tgt_write   = (w.req_type == rmfp_pkg::REQ_WRITE);
            parse_phase = rmfp_pkg::PH_PRE1;
            rx_count    = '0;
            rx_sum      = '0;
            fr[0] = rmfp_pkg::PREAMBLE;
            fr[1] = rmfp_pkg::PREAMBLE;
            fr[2] = cmd;
            fr[3] = model_slave;
            fr[4] = val;
            fr[5] = idx;
            fr[6] = 8'h00;
            fr[7] = cmd + model_slave + val + idx;
            for (int i = 0; i < rmfp_pkg::FRAME_LEN; i++)
            begin
                r.kind       = 1'b0;
                r.tx         = fr[i];
                r.last       = (i == rmfp_pkg::FRAME_LEN - 1);
                r.status     = rmfp_pkg::ST_OK;
                r.read_value = 8'h00;
                reply_q.push_back(r);
            end
            frames_sent++;
        end
        else if (w.req_type == rmfp_pkg::REQ_RX)
        begin
            case (parse_phase)
                rmfp_pkg::PH_PRE1:
                begin
                    if (w.rx_byte == rmfp_pkg::PREAMBLE)
                        parse_phase = rmfp_pkg::PH_PRE2;
                end
                rmfp_pkg::PH_PRE2:
                begin
                    // second preamble byte missing: hunt for the first again
                    parse_phase = (w.rx_byte == rmfp_pkg::PREAMBLE) ? rmfp_pkg::PH_BODY
                                                                     : rmfp_pkg::PH_PRE1;
                    rx_count    = '0;
                    rx_sum      = '0;
                end
                rmfp_pkg::PH_BODY:
                begin
                    rx_body[rx_count] = w.rx_byte;
                    rx_sum   = rx_sum + w.rx_byte;
                    rx_count = rx_count + 3'd1;
                    if (rx_count >= rmfp_pkg::BODY_LEN)
                        parse_phase = rmfp_pkg::PH_SUM;
                end
                rmfp_pkg::PH_SUM:
                begin
                    // checks in priority order, first failure wins
                    if (w.rx_byte != rx_sum)
                        st = rmfp_pkg::ST_CHECKSUM;
                    else if (rx_body[0] != tgt_cmd)
                        st = rmfp_pkg::ST_BAD_CMD;
                    else if (rx_body[1] != 8'h00)
                        st = rmfp_pkg::ST_BAD_MOD;
                    else if (rx_body[3] != tgt_index)
                        st = rmfp_pkg::ST_INDEX;
                    else if (tgt_write && rx_body[2] != tgt_value)
                        st = rmfp_pkg::ST_VALUE;
                    else
                        st = rmfp_pkg::ST_OK;
                    r.kind   = 1'b1;
                    r.tx     = 8'h00;
                    r.last   = 1'b0;
                    r.status = st;
                    if (st == rmfp_pkg::ST_OK && !tgt_write)
                        r.read_value = tgt_relay ? {7'd0, rx_body[2] != 8'h00} : rx_body[2];
                    else
                        r.read_value = 8'h00;
                    reply_q.push_back(r);
                    status_seen[st]++;
                    parse_phase = rmfp_pkg::PH_IDLE;
                    rx_count    = '0;
                    rx_sum      = '0;
                end
                default:
                    ignored = 1'b1;  // byte while idle
            endcase
        end
        else
        begin
            ignored = 1'b1;  // unused request code
        end
    endtask

    // offer one word, wait for the handshake, update the model, maybe idle
    task automatic send_word(input in_word_t w, input logic typed = 1'b0,
                             input rmfp_pkg::status_t st = rmfp_pkg::ST_OK,
                             input logic [7:0] rv = 8'h00);
        bit          ign;
        reply_word_t r;
        in_valid    <= 1'b1;
        req_type    <= w.req_type;
        reg_kind    <= w.reg_kind;
        reg_address <= w.reg_address;
        write_value <= w.write_value;
        rx_byte     <= w.rx_byte;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(w, ign);
        // hand-typed done word replaces the modeled one
        if (typed)
        begin
            r = reply_q.pop_back();
            r.status     = st;
            r.read_value = rv;
            reply_q.push_back(r);
        end
        if (!ign)
            items_sent++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && words_seen >= 60)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // output check against the oldest queued word
    always @(posedge clk)
    begin
        reply_word_t exp_w;
        reply_word_t got_w;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            got_w.kind       = result_kind;
            got_w.tx         = tx_byte;
            got_w.last       = last;
            got_w.status     = rmfp_pkg::status_t'(status);
            got_w.read_value = read_value;
            if (reply_q.size() == 0)
            begin
                flag_error($sformatf("unexpected word kind=%0d tx=%02h last=%0d st=%0d rv=%02h",
                                     got_w.kind, got_w.tx, got_w.last, got_w.status,
                                     got_w.read_value));
            end
            else
            begin
                exp_w = reply_q.pop_front();
                if (got_w.kind !== exp_w.kind || got_w.tx !== exp_w.tx
                    || got_w.last !== exp_w.last || got_w.status !== exp_w.status
                    || got_w.read_value !== exp_w.read_value)
                    flag_error($sformatf({"exp kind=%0d tx=%02h last=%0d st=%0d rv=%02h",
                                          " got kind=%0d tx=%02h last=%0d st=%0d rv=%02h"},
                                         exp_w.kind, exp_w.tx, exp_w.last, exp_w.status,
                                         exp_w.read_value, got_w.kind, got_w.tx, got_w.last,
                                         got_w.status, got_w.read_value));
            end
        end
    end

    // stimulus
    initial
    begin
        in_word_t   w;
        logic [7:0] body [rmfp_pkg::BODY_LEN];
        logic [7:0] sum;
        logic [7:0] reply [rmfp_pkg::FRAME_LEN];
        logic [7:0] slave_tab [4];
        int         flaw;
        int         n;
        bit         paused;

        paused = 1'b0;
        for (int i = 0; i < rmfp_pkg::BODY_LEN; i++)
            rx_body[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, slave id still at its reset value
        dir_tab.push_back('{rx_w(8'h5A), 1'b0, rmfp_pkg::ST_OK, 8'h00});  // byte while idle
        dir_tab.push_back('{rq_w(REQ_UNUSED, 2'd1, 16'h1234, 8'h55), 1'b0,
                            rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rq_w(rmfp_pkg::REQ_WRITE, rmfp_pkg::KIND_RELAY, 16'hFFFF, 8'h01),
                            1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        // new request abandons the half-parsed reply
        dir_tab.push_back('{rq_w(rmfp_pkg::REQ_READ, rmfp_pkg::KIND_RELAY, 16'h0012, 8'hFF),
                            1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b0, rmfp_pkg::ST_OK, 8'h00});  // not a preamble
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h12), 1'b0, rmfp_pkg::ST_OK, 8'h00});  // second FF missing
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(rmfp_pkg::CMD_READ), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h01), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h12), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h18), 1'b1, rmfp_pkg::ST_OK, 8'h01});  // relay reads back 1
        dir_tab.push_back('{rq_w(rmfp_pkg::REQ_WRITE, rmfp_pkg::KIND_BRIGHT, 16'hAB34, 8'h80),
                            1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'hFF), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(rmfp_pkg::CMD_BRIGHT), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h80), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'hAB), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b0, rmfp_pkg::ST_OK, 8'h00});
        dir_tab.push_back('{rx_w(8'h00), 1'b1, rmfp_pkg::ST_CHECKSUM, 8'h00});  // bad checksum
        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].st, dir_tab[i].rv);

        // random transactions, one slave id per phase
        items_sent   = 0;
        slave_tab[0] = 8'hFF;
        slave_tab[1] = 8'($urandom_range(1, 254));
        slave_tab[2] = 8'h00;
        slave_tab[3] = 8'($urandom_range(1, 254));
        for (int p = 0; p < 4; p++)
        begin
            // drain, let the pipeline settle, then change the slave id
            in_valid <= 1'b0;
            while (reply_q.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= slave_tab[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            model_slave = slave_tab[p];

            while (items_sent < RANDOM_ITEMS * (p + 1) / 4)
            begin
                if (p == 3 && items_sent >= RANDOM_ITEMS * 7 / 8)
                    calm = 1'b1;
                // sender pause until every queued word is out
                if (p == 1 && !paused && items_sent >= RANDOM_ITEMS * 3 / 8)
                begin
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (reply_q.size() != 0);
                end

                // occasional noise ahead of the request
                case ($urandom_range(0, 9))
                    0: send_word(rx_w(8'($urandom_range(0, 255))));
                    1: send_word(rq_w(REQ_UNUSED, 2'($urandom_range(0, 3)),
                                      16'($urandom_range(0, 65535)),
                                      8'($urandom_range(0, 255))));
                    default: ;
                endcase

                // request
                case ($urandom_range(0, 3))
                    0:       n = 0;
                    1:       n = 255;
                    default: n = $urandom_range(0, 255);
                endcase
                w = rq_w($urandom_range(0, 1) ? rmfp_pkg::REQ_WRITE : rmfp_pkg::REQ_READ,
                         2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), 8'(n));
                send_word(w);

                // reply built from what the request now expects
                body[0] = tgt_cmd;
                body[1] = 8'h00;
                if (tgt_write)
                    body[2] = tgt_value;
                else
                    body[2] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                body[3] = tgt_index;
                body[4] = 8'($urandom_range(0, 255));
                flaw = $urandom_range(0, 11);
                case (flaw)
                    6: body[0] = body[0] ^ 8'($urandom_range(1, 255));
                    7: body[1] = 8'($urandom_range(1, 255));
                    8: body[3] = body[3] ^ 8'($urandom_range(1, 255));
                    9: body[2] = body[2] ^ 8'($urandom_range(1, 255));
                    default: ;
                endcase
                sum = body[0] + body[1] + body[2] + body[3] + body[4];
                if (flaw == 10)
                    sum = sum ^ 8'($urandom_range(1, 255));
                // a cut reply is abandoned by the next request
                n = (flaw == 11) ? $urandom_range(0, 7) : rmfp_pkg::FRAME_LEN;

                // line noise and broken preambles
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(rx_w(8'($urandom_range(0, 254))));
                if ($urandom_range(0, 6) == 0)
                begin
                    send_word(rx_w(rmfp_pkg::PREAMBLE));
                    send_word(rx_w(8'($urandom_range(0, 254))));
                end

                reply[0] = rmfp_pkg::PREAMBLE;
                reply[1] = rmfp_pkg::PREAMBLE;
                for (int i = 0; i < rmfp_pkg::BODY_LEN; i++)
                    reply[2 + i] = body[i];
                reply[7] = sum;
                for (int i = 0; i < n; i++)
                    send_word(rx_w(reply[i]));
            end
        end

        // wind down
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reply_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d directed and %0d random words across four slave id settings:",
                 dir_tab.size(), items_sent);
        $display("  %0d frames, %0d words out; reply status ok/sum/cmd/mod/idx/val: %0d/%0d/%0d/%0d/%0d/%0d",
                 frames_sent, words_seen,
                 status_seen[rmfp_pkg::ST_OK], status_seen[rmfp_pkg::ST_CHECKSUM],
                 status_seen[rmfp_pkg::ST_BAD_CMD], status_seen[rmfp_pkg::ST_BAD_MOD],
                 status_seen[rmfp_pkg::ST_INDEX], status_seen[rmfp_pkg::ST_VALUE]);
        if (errors == 0)
            $display("PASS relay_module_frame_protocol_master_top");
        else
            $display("FAIL relay_module_frame_protocol_master_top");
        $finish;
    end

endmodule

[sim.f]
rtl/rmfp_pkg.sv
rtl/rmfp_parser.sv
rtl/rmfp_tx.sv
rtl/relay_module_frame_protocol_master_top.sv
bench/tb_relay_module_frame_protocol_master_top.sv
